### rtl/modbus_ascii_frame_decoder_unit_macros.svh
// Assertion macros for the frame decoder RTL.
`ifndef MODBUS_ASCII_FRAME_DECODER_UNIT_MACROS_SVH
`define MODBUS_ASCII_FRAME_DECODER_UNIT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define MAFD_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Property checked on every clock edge, reset included.
`define MAFD_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/mafd_pkg.sv
// Types, constants and helpers for the Modbus ASCII frame decoder.
package mafd_pkg;

	localparam int unsigned MAX_FRAME_CHARS = 513;
	localparam logic [9:0] COUNT_MAX = 10'd1023;
	localparam logic [9:0] FRAME_CHARS_MAX = 10'(MAX_FRAME_CHARS);
	localparam logic [9:0] FLOOR_MIN_CHARS = 10'd7;
	localparam logic [8:0] CAPACITY_RESET = 9'd256;
	localparam logic [9:0] MIN_CHARS_RESET = 10'd9;
	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;

	// configuration register indexes
	localparam logic CFG_BYTE_LIMIT = 1'b0;
	localparam logic CFG_MIN_FRAME_CHARS = 1'b1;

	typedef enum logic {
		KIND_DATA = 1'b0,
		KIND_STATUS = 1'b1
	} kind_t;

	typedef enum logic [3:0] {
		ST_OK = 4'd0,
		ST_SHORT = 4'd1,
		ST_LONG = 4'd2,
		ST_NO_START = 4'd3,
		ST_NO_CRLF = 4'd4,
		ST_ODD = 4'd5,
		ST_CAPACITY = 4'd6,
		ST_BAD_HEX = 4'd7,
		ST_LRC = 4'd8
	} status_t;

	typedef struct packed {
		logic [8:0] byte_limit;
		logic [9:0] min_frame_chars;
	} cfg_t;

	typedef struct packed {
		kind_t kind;
		logic [7:0] data_byte;
		logic [7:0] byte_index;
		status_t status;
		logic [7:0] station_address;
		logic [7:0] payload_len;
		logic run_end;
	} res_t;

	// up to two results per character, byte first
	typedef struct packed {
		logic byte_vld;
		res_t byte_res;
		logic stat_vld;
		res_t stat_res;
	} push_t;

	// {valid, nibble}
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end
		return r;
	endfunction

endpackage

### rtl/mafd_frame_core.sv
// Per-character frame state, hex pair decode, LRC sum and end-of-frame judgment.
module mafd_frame_core (
	input logic clk,
	input logic arst_n,
	input logic step,
	input logic [7:0] frame_char,
	input logic final_char,
	input mafd_pkg::cfg_t cfg,
	output mafd_pkg::push_t push
);
	import mafd_pkg::*;

	logic [9:0] char_count_q, char_count_n;
	logic [7:0] hist0_q, hist0_n, hist1_q, hist1_n;
	logic [3:0] high_nibble_q, high_nibble_n;
	logic nibble_phase_q, nibble_phase_n;
	logic [7:0] byte_sum_q, byte_sum_n;
	logic [7:0] first_byte_q, first_byte_n;
	logic start_seen_q, start_seen_n;
	logic hex_fault_q, hex_fault_n;

	logic [4:0] hv;
	logic [7:0] dec_byte;
	logic [9:0] p_minus4;
	logic [8:0] idx;
	logic [9:0] lo;
	logic [9:0] total_minus3;
	logic [8:0] dec;
	status_t st;

	always_comb begin
		char_count_n = char_count_q;
		hist0_n = frame_char;
		hist1_n = hist0_q;
		high_nibble_n = high_nibble_q;
		nibble_phase_n = nibble_phase_q;
		byte_sum_n = byte_sum_q;
		first_byte_n = first_byte_q;
		start_seen_n = start_seen_q;
		hex_fault_n = hex_fault_q;
		hv = hex_value(hist1_q);
		dec_byte = {high_nibble_q, hv[3:0]};
		p_minus4 = char_count_q - 10'd4;
		idx = p_minus4[9:1];
		push = '0;

		if (char_count_q == 10'd0) begin
			start_seen_n = (frame_char == CHAR_COLON);
		end else if (char_count_q >= 10'd3) begin
			if (!hv[4]) begin
				hex_fault_n = 1'b1;
			end
			if (!nibble_phase_q) begin
				high_nibble_n = hv[3:0];
				nibble_phase_n = 1'b1;
			end else begin
				nibble_phase_n = 1'b0;
				byte_sum_n = byte_sum_q + dec_byte;
				if (idx == 9'd0) begin
					first_byte_n = dec_byte;
				end
				if (start_seen_n && !hex_fault_n && idx < cfg.byte_limit
						&& idx <= 9'd255) begin
					push.byte_vld = 1'b1;
					push.byte_res.kind = KIND_DATA;
					push.byte_res.data_byte = dec_byte;
					push.byte_res.byte_index = idx[7:0];
					push.byte_res.status = ST_OK;
					push.byte_res.run_end = !final_char;
				end
			end
		end

		if (char_count_q != COUNT_MAX) begin
			char_count_n = char_count_q + 10'd1;
		end

		// end-of-frame checks in priority order
		lo = (cfg.min_frame_chars < FLOOR_MIN_CHARS) ? FLOOR_MIN_CHARS : cfg.min_frame_chars;
		total_minus3 = char_count_n - 10'd3;
		dec = total_minus3[9:1];
		if (char_count_n < lo) begin
			st = ST_SHORT;
		end else if (char_count_n > FRAME_CHARS_MAX) begin
			st = ST_LONG;
		end else if (!start_seen_n) begin
			st = ST_NO_START;
		end else if (hist1_n != CHAR_CR || hist0_n != CHAR_LF) begin
			st = ST_NO_CRLF;
		end else if (total_minus3[0]) begin
			st = ST_ODD;
		end else if (dec > 9'd255) begin
			st = ST_LONG;
		end else if (cfg.byte_limit < dec) begin
			st = ST_CAPACITY;
		end else if (hex_fault_n) begin
			st = ST_BAD_HEX;
		end else if (byte_sum_n != 8'd0) begin
			st = ST_LRC;
		end else begin
			st = ST_OK;
		end

		if (final_char) begin
			push.stat_vld = 1'b1;
			push.stat_res.kind = KIND_STATUS;
			push.stat_res.status = st;
			push.stat_res.run_end = 1'b1;
			if (st == ST_OK) begin
				push.stat_res.station_address = first_byte_n;
				push.stat_res.payload_len = 8'(dec - 9'd2);
			end
		end

		if (!step) begin
			push.byte_vld = 1'b0;
			push.stat_vld = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_count_q <= '0;
			hist0_q <= '0;
			hist1_q <= '0;
			high_nibble_q <= '0;
			nibble_phase_q <= 1'b0;
			byte_sum_q <= '0;
			first_byte_q <= '0;
			start_seen_q <= 1'b0;
			hex_fault_q <= 1'b0;
		end else if (step) begin
			if (final_char) begin
				char_count_q <= '0;
				hist0_q <= '0;
				hist1_q <= '0;
				high_nibble_q <= '0;
				nibble_phase_q <= 1'b0;
				byte_sum_q <= '0;
				first_byte_q <= '0;
				start_seen_q <= 1'b0;
				hex_fault_q <= 1'b0;
			end else begin
				char_count_q <= char_count_n;
				hist0_q <= hist0_n;
				hist1_q <= hist1_n;
				high_nibble_q <= high_nibble_n;
				nibble_phase_q <= nibble_phase_n;
				byte_sum_q <= byte_sum_n;
				first_byte_q <= first_byte_n;
				start_seen_q <= start_seen_n;
				hex_fault_q <= hex_fault_n;
			end
		end
	end

endmodule

### rtl/mafd_out_queue.sv
// Four-entry result queue: takes up to two results per cycle, delivers one.
module mafd_out_queue (
	input logic clk,
	input logic arst_n,
	input mafd_pkg::push_t push,
	output logic room,
	output logic out_valid,
	input logic out_ready,
	output mafd_pkg::res_t out_res
);
	import mafd_pkg::*;

	res_t entries_q [QUEUE_DEPTH];
	logic [1:0] wr_ptr_q, rd_ptr_q;
	logic [2:0] cnt_q, cnt_n;
	logic pop;
	logic [1:0] wr_ptr_b;
	logic [2:0] npush;

	assign out_valid = (cnt_q != 3'd0);
	assign out_res = entries_q[rd_ptr_q];
	assign pop = out_valid && out_ready;
	// two free slots needed before a character may advance
	assign room = (cnt_q <= 3'd2);
	assign npush = {2'b00, push.byte_vld} + {2'b00, push.stat_vld};
	assign wr_ptr_b = wr_ptr_q + {1'b0, push.byte_vld};
	assign cnt_n = cnt_q + npush - {2'b00, pop};

	always_ff @(posedge clk) begin
		if (push.byte_vld) begin
			entries_q[wr_ptr_q] <= push.byte_res;
		end
		if (push.stat_vld) begin
			entries_q[wr_ptr_b] <= push.stat_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + npush[1:0];
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			cnt_q <= cnt_n;
		end
	end

	`include "modbus_ascii_frame_decoder_unit_macros.svh"

	`MAFD_ASSERT_RST(a_cnt_bound, cnt_q <= 3'(QUEUE_DEPTH), "queue count beyond depth")
	`MAFD_ASSERT_RST(a_push_room, (push.byte_vld || push.stat_vld) |-> cnt_q <= 3'd2, "push, no room")
	`MAFD_ASSERT_RST(a_pair_order, (push.byte_vld && push.stat_vld) |-> !push.byte_res.run_end, "byte ends run")

endmodule

### rtl/modbus_ascii_frame_decoder_unit.sv
// Top level of the Modbus ASCII frame decoder.
// Usage:
//   s_* carries one frame character per transaction in s_tdata[7:0]; s_tlast marks
//   the final character of a frame (normally the LF of CR LF).
//   m_* carries results: tuser 0 = decoded data byte with its index, tuser 1 =
//   end-of-frame status with station address and PDU length (zero unless ok).
//   m_tlast marks the last result caused by one character.
//   cfg_we/cfg_index/cfg_data write the decoded byte limit (0) and min_frame_chars (1);
//   write only while the block is idle.
// Timing: a character is registered, then judged once the queue has room; its
//   results are written into the output queue as it advances. One character
//   per cycle is sustained while the receiver takes results; a final character
//   that also completes a byte yields two results and the queue drains them one
//   per cycle. The four-entry output queue sets the rate under output stalls:
//   a character advances only while two queue slots are free, so s_tready drops
//   once the receiver holds back results.
// Reset clears frame state, queue and configuration (byte limit 256, minimum 9).
// Data bytes are sent before the frame is judged; discard them unless status ok.
module modbus_ascii_frame_decoder_unit (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [7:0] s_tdata, // [7:0] frame_char
	input logic s_tlast,
	output logic m_tvalid,
	input logic m_tready,
	output logic [39:0] m_tdata, // [7:0] data_byte, [15:8] byte_index, [19:16] status,
	                             // [27:20] station_address, [35:28] payload_len, rest 0
	output logic m_tuser, // [0] kind
	output logic m_tlast,
	input logic cfg_we,
	input logic cfg_index,
	input logic [9:0] cfg_data
);
	import mafd_pkg::*;

	cfg_t cfg_q;
	logic valid_s1;
	logic [7:0] char_s1;
	logic final_s1;
	logic room;
	logic adv;
	push_t push;
	res_t head;

	assign adv = valid_s1 && room;
	assign s_tready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.byte_limit <= CAPACITY_RESET;
			cfg_q.min_frame_chars <= MIN_CHARS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BYTE_LIMIT: cfg_q.byte_limit <= cfg_data[8:0];
				CFG_MIN_FRAME_CHARS: cfg_q.min_frame_chars <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			final_s1 <= s_tlast;
		end
	end

	mafd_frame_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.step(adv),
		.frame_char(char_s1),
		.final_char(final_s1),
		.cfg(cfg_q),
		.push(push)
	);

	mafd_out_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.room(room),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res(head)
	);

	assign m_tdata = {4'b0000, head.payload_len, head.station_address, head.status,
		head.byte_index, head.data_byte};
	assign m_tuser = head.kind;
	assign m_tlast = head.run_end;

endmodule
